@@ rtl/core/drbs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and widths for the descriptor record byte swapper
// no dependencies; imported by every module of the block

package drbs_pkg;

    // defaults for the top level parameters
    localparam int DEFAULT_MAX_DESCRIPTORS = 32;
    localparam int DEFAULT_LENGTH_BITS     = 16;

    // descriptor slots that the index field can reach
    localparam int SLOT_LIMIT = 32;

    // input field widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 5;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 13;
    localparam int MODE_W   = 2;
    localparam int RECLEN_W = 16;
    localparam int BYTE_W   = 8;

    // input tdata layout, first field lowest
    localparam int INDEX_LSB  = 0;
    localparam int KIND_LSB   = INDEX_LSB + INDEX_W;
    localparam int COUNT_LSB  = KIND_LSB + KIND_W;
    localparam int MODE_LSB   = COUNT_LSB + COUNT_W;
    localparam int RECLEN_LSB = MODE_LSB + MODE_W;
    localparam int BYTE_LSB   = RECLEN_LSB + RECLEN_W;
    localparam int IN_FIELDS_W = BYTE_LSB + BYTE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = BYTE_W;

    // group collection widths
    localparam int GROUP_W = 3 * BYTE_W;
    localparam int OBUF_W  = 4 * BYTE_W;

    // word function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_START = 2'd1,
        FUNC_BYTE  = 2'd2
    } func_t;

    // descriptor run kinds
    localparam logic [KIND_W-1:0] KIND_END    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTES  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HALVES = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WORDS  = 2'd3;

    // record modes
    localparam logic [MODE_W-1:0] MODE_HALVES = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WORDS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

    // one descriptor table entry
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
    } desc_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_SUM  = 3'd1,
        S_PASS = 3'd2,
        S_FIND = 3'd3,
        S_EMIT = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_desc;
        logic start_rec;
        logic take_byte;
        logic sum_step;
        logic pass_load;
        logic find_step;
        logic out_pop;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sum_last;
        logic pass_go;
        logic byte_emits;
        logic byte_finds;
        logic find_done;
        logic find_pend;
        logic out_last;
    } dp_status_t;

endpackage

@@ rtl/core/drbs_ctrl.sv @@
`timescale 1ns / 1ps
// sequencing state machine for the descriptor record byte swapper
// depends on drbs_pkg; drives commands into drbs_dp

module drbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [drbs_pkg::FUNC_W-1:0] in_func,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output drbs_pkg::dp_cmd_t      cmd,
    input  drbs_pkg::dp_status_t   status
);
    import drbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (func_t'(in_func))
                        FUNC_WRITE:
                        begin
                            cmd.wr_desc = 1'b1;
                        end
                        FUNC_START:
                        begin
                            cmd.start_rec = 1'b1;
                            state_next    = S_SUM;
                        end
                        FUNC_BYTE:
                        begin
                            cmd.take_byte = 1'b1;
                            if (status.byte_emits)
                            begin
                                state_next = S_EMIT;
                            end
                            else if (status.byte_finds)
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_last)
                begin
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.pass_load = 1'b1;
                state_next    = status.pass_go ? S_FIND : S_IDLE;
            end
            S_FIND:
            begin
                cmd.find_step = 1'b1;
                if (status.find_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_pop = 1'b1;
                    if (status.out_last)
                    begin
                        state_next = status.find_pend ? S_FIND : S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/drbs_dp.sv @@
`timescale 1ns / 1ps
// datapath: descriptor table, record counters, group collection and output buffer
// depends on drbs_pkg; commanded by drbs_ctrl

module drbs_dp #(
    parameter int TABLE_DEPTH = drbs_pkg::DEFAULT_MAX_DESCRIPTORS,
    parameter int LENGTH_BITS = drbs_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drbs_pkg::dp_cmd_t               cmd,
    output drbs_pkg::dp_status_t            status,
    input  logic [drbs_pkg::INDEX_W-1:0]    desc_index,
    input  logic [drbs_pkg::KIND_W-1:0]     desc_kind,
    input  logic [drbs_pkg::COUNT_W-1:0]    desc_count,
    input  logic [drbs_pkg::MODE_W-1:0]     record_mode,
    input  logic [drbs_pkg::RECLEN_W-1:0]   record_length,
    input  logic [drbs_pkg::BYTE_W-1:0]     data_byte,
    output logic [drbs_pkg::BYTE_W-1:0]     out_byte,
    output logic                            run_last,
    output logic                            record_end
);
    import drbs_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_W = $clog2(TABLE_DEPTH + 1);
    // pass total without saturation: depth times largest run in bytes
    localparam int SUM_W  = COUNT_W + 2 + IDX_W;
    localparam int CMP_W  = (SUM_W > LENGTH_BITS) ? SUM_W : LENGTH_BITS;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // descriptor table with per-entry valid bits
    desc_t desc_reg  [TABLE_DEPTH];
    logic  valid_reg [TABLE_DEPTH];

    logic [MODE_W-1:0]      mode_reg,       mode_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [LENGTH_BITS-1:0] pass_length_reg, pass_length_next;
    logic [SUM_W-1:0]       total_reg,      total_next;
    logic [SLOT_W-1:0]      scan_reg,       scan_next;
    logic [KIND_W-1:0]      cur_kind_reg,   cur_kind_next;
    logic [COUNT_W-1:0]     run_left_reg,   run_left_next;
    logic [1:0]             gpos_reg,       gpos_next;
    logic [GROUP_W-1:0]     gbytes_reg,     gbytes_next;
    logic                   in_pass_reg,    in_pass_next;
    logic                   wrap_reg,       wrap_next;
    logic                   find_pend_reg,  find_pend_next;
    logic [OBUF_W-1:0]      obuf_reg,       obuf_next;
    logic [2:0]             ocnt_reg,       ocnt_next;
    logic                   oend_reg,       oend_next;

    logic                   in_range;
    logic [IDX_W-1:0]       rd_idx;
    desc_t                  rd_ent;
    logic                   end_of_list;
    logic [SUM_W-1:0]       term;
    logic [LENGTH_BITS-1:0] pass_sat;
    logic                   retry_ok;
    logic                   find_retry;
    logic                   bl_zero;
    logic [LENGTH_BITS-1:0] bl_dec;
    logic [1:0]             lastpos;
    logic                   short_grp;
    logic                   collect;
    logic                   single;
    logic                   advancing;
    logic                   run_out;
    logic                   wr_ok;

    // table read at the scan pointer
    assign in_range    = scan_reg < SLOT_W'(TABLE_DEPTH);
    assign rd_idx      = scan_reg[IDX_W-1:0];
    assign rd_ent      = (in_range && valid_reg[rd_idx]) ? desc_reg[rd_idx] : '0;
    assign end_of_list = !in_range || (rd_ent.kind == KIND_END);

    // run length in bytes
    always_comb
    begin
        case (rd_ent.kind)
            KIND_WORDS:  term = SUM_W'(rd_ent.count) << 2;
            KIND_HALVES: term = SUM_W'(rd_ent.count) << 1;
            default:     term = SUM_W'(rd_ent.count);
        endcase
    end

    // pass length saturates at the largest length value
    assign pass_sat = (CMP_W'(total_reg) > CMP_W'(LEN_MAX)) ? LEN_MAX
                                                             : LENGTH_BITS'(total_reg);

    // another full pass still fits
    assign retry_ok   = (bytes_left_reg != '0) && (pass_length_reg != '0)
                        && (bytes_left_reg >= pass_length_reg);
    assign find_retry = end_of_list && !wrap_reg && retry_ok;

    // group size of the current byte, as index of the group's last byte
    always_comb
    begin
        if (in_pass_reg)
        begin
            case (cur_kind_reg)
                KIND_HALVES: lastpos = 2'd1;
                KIND_WORDS:  lastpos = 2'd3;
                default:     lastpos = 2'd0;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_HALVES: lastpos = 2'd1;
                MODE_WORDS:  lastpos = 2'd3;
                default:     lastpos = 2'd0;
            endcase
        end
    end

    assign bl_zero   = bytes_left_reg == '0;
    assign bl_dec    = bytes_left_reg - LENGTH_BITS'(1);
    assign short_grp = (lastpos != 2'd0) && (gpos_reg == 2'd0)
                       && (bytes_left_reg <= LENGTH_BITS'(lastpos));
    assign collect   = !short_grp && (lastpos != 2'd0) && (gpos_reg < lastpos);
    assign single    = short_grp || (lastpos == 2'd0);
    assign advancing = in_pass_reg && !short_grp && !collect;
    assign run_out   = run_left_reg == COUNT_W'(1);
    assign wr_ok     = cmd.wr_desc && bl_zero && (32'(desc_index) < 32'(TABLE_DEPTH));

    // status back to the controller
    always_comb
    begin
        status            = '0;
        status.sum_last   = end_of_list;
        status.pass_go    = !bl_zero && (mode_reg == MODE_LIST) && (total_reg != '0);
        status.byte_emits = !bl_zero && !collect;
        status.byte_finds = !bl_zero && advancing && run_out && (bl_dec != '0);
        status.find_done  = (end_of_list && !find_retry)
                            || (!end_of_list && (rd_ent.count != '0));
        status.find_pend  = find_pend_reg;
        status.out_last   = ocnt_reg == 3'd1;
    end

    // next state of the record registers
    always_comb
    begin
        mode_next        = mode_reg;
        bytes_left_next  = bytes_left_reg;
        pass_length_next = pass_length_reg;
        total_next       = total_reg;
        scan_next        = scan_reg;
        cur_kind_next    = cur_kind_reg;
        run_left_next    = run_left_reg;
        gpos_next        = gpos_reg;
        gbytes_next      = gbytes_reg;
        in_pass_next     = in_pass_reg;
        wrap_next        = wrap_reg;
        find_pend_next   = find_pend_reg;
        obuf_next        = obuf_reg;
        ocnt_next        = ocnt_reg;
        oend_next        = oend_reg;

        // record start clears the walk and the group
        if (cmd.start_rec)
        begin
            mode_next       = record_mode;
            bytes_left_next = LENGTH_BITS'(record_length);
            total_next      = '0;
            scan_next       = '0;
            run_left_next   = '0;
            gpos_next       = 2'd0;
            gbytes_next     = '0;
            in_pass_next    = 1'b0;
            find_pend_next  = 1'b0;
        end

        // one table entry per cycle into the pass total
        if (cmd.sum_step && !end_of_list)
        begin
            total_next = total_reg + term;
            scan_next  = scan_reg + SLOT_W'(1);
        end

        // pass length ready, first run search starts at slot zero
        if (cmd.pass_load)
        begin
            pass_length_next = pass_sat;
            scan_next        = '0;
            wrap_next        = 1'b1;
        end

        // run search, one slot per cycle
        if (cmd.find_step)
        begin
            if (end_of_list)
            begin
                if (find_retry)
                begin
                    scan_next = '0;
                    wrap_next = 1'b1;
                end
                else
                begin
                    in_pass_next   = 1'b0;
                    find_pend_next = 1'b0;
                end
            end
            else if (rd_ent.count != '0)
            begin
                cur_kind_next  = rd_ent.kind;
                run_left_next  = rd_ent.count;
                in_pass_next   = 1'b1;
                find_pend_next = 1'b0;
            end
            else
            begin
                scan_next = scan_reg + SLOT_W'(1);
            end
        end

        // data byte
        if (cmd.take_byte && !bl_zero)
        begin
            bytes_left_next = bl_dec;
            if (collect)
            begin
                gbytes_next = gbytes_reg | (GROUP_W'(data_byte) << {gpos_reg, 3'b000});
                gpos_next   = gpos_reg + 2'd1;
            end
            else
            begin
                oend_next = bl_dec == '0;
                if (single)
                begin
                    obuf_next = OBUF_W'(data_byte);
                    ocnt_next = 3'd1;
                end
                else if (gpos_reg == 2'd1)
                begin
                    obuf_next = OBUF_W'({gbytes_reg[7:0], data_byte});
                    ocnt_next = 3'd2;
                end
                else
                begin
                    obuf_next = {gbytes_reg[7:0], gbytes_reg[15:8], gbytes_reg[23:16],
                                 data_byte};
                    ocnt_next = 3'd4;
                end
                gpos_next   = 2'd0;
                gbytes_next = '0;
                if (advancing)
                begin
                    if (!run_out)
                    begin
                        run_left_next = run_left_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        run_left_next  = '0;
                        scan_next      = scan_reg + SLOT_W'(1);
                        wrap_next      = 1'b0;
                        find_pend_next = bl_dec != '0;
                    end
                end
            end
            if (bl_dec == '0)
            begin
                in_pass_next = 1'b0;
                gpos_next    = 2'd0;
                gbytes_next  = '0;
            end
        end

        // output buffer drains low byte first
        if (cmd.out_pop)
        begin
            obuf_next = obuf_reg >> BYTE_W;
            ocnt_next = ocnt_reg - 3'd1;
        end
    end

    // record registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            bytes_left_reg  <= '0;
            pass_length_reg <= '0;
            total_reg       <= '0;
            scan_reg        <= '0;
            cur_kind_reg    <= '0;
            run_left_reg    <= '0;
            gpos_reg        <= 2'd0;
            gbytes_reg      <= '0;
            in_pass_reg     <= 1'b0;
            wrap_reg        <= 1'b0;
            find_pend_reg   <= 1'b0;
            ocnt_reg        <= 3'd0;
            oend_reg        <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            bytes_left_reg  <= bytes_left_next;
            pass_length_reg <= pass_length_next;
            total_reg       <= total_next;
            scan_reg        <= scan_next;
            cur_kind_reg    <= cur_kind_next;
            run_left_reg    <= run_left_next;
            gpos_reg        <= gpos_next;
            gbytes_reg      <= gbytes_next;
            in_pass_reg     <= in_pass_next;
            wrap_reg        <= wrap_next;
            find_pend_reg   <= find_pend_next;
            ocnt_reg        <= ocnt_next;
            oend_reg        <= oend_next;
        end
    end

    // output byte buffer
    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
    end

    // valid bits, cleared at reset so every entry reads as end of list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_ok)
        begin
            valid_reg[desc_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    // descriptor entries
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            desc_reg[desc_index[IDX_W-1:0]] <= '{kind: desc_kind, count: desc_count};
        end
    end

    // result word
    assign out_byte   = obuf_reg[BYTE_W-1:0];
    assign run_last   = ocnt_reg == 3'd1;
    assign record_end = (ocnt_reg == 3'd1) && oend_reg;

endmodule

@@ rtl/core/descriptor_record_byte_swapper.sv @@
`timescale 1ns / 1ps
// top level of the descriptor record byte swapper: stream ports, controller, datapath
// depends on drbs_pkg, drbs_ctrl and drbs_dp
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata fields, tuser = function
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata = byte, tuser = run_last,
//                                              tlast = record_end
//
// after a descriptor write or a data byte that gives no output the input is ready
// again in the next cycle; a byte that completes a group holds the input while its
// result bytes (1, 2 or 4) drain; a record start walks the table slots for the pass
// total and, in list mode, scans slots for the first run before the input is ready
// when a run ends mid record the next run is searched one slot per cycle over the
// single table read port
// reset is asynchronous and clears the table to end of list through valid bits
// input is not taken while result bytes are waiting; an output stall holds the block

module descriptor_record_byte_swapper #(
    parameter int MAX_DESCRIPTORS = drbs_pkg::DEFAULT_MAX_DESCRIPTORS,
    parameter int LENGTH_BITS     = drbs_pkg::DEFAULT_LENGTH_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // desc_index, desc_kind, desc_count, record_mode, record_length, data_byte
    input  logic [drbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [drbs_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte
    output logic [drbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // run_last
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import drbs_pkg::*;

    // slots beyond the index field's reach stay end of list
    localparam int TABLE_DEPTH = (MAX_DESCRIPTORS < SLOT_LIMIT) ? MAX_DESCRIPTORS
                                                                : SLOT_LIMIT;

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller
    drbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    drbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .desc_index    (s_axis_tdata[INDEX_LSB +: INDEX_W]),
        .desc_kind     (s_axis_tdata[KIND_LSB +: KIND_W]),
        .desc_count    (s_axis_tdata[COUNT_LSB +: COUNT_W]),
        .record_mode   (s_axis_tdata[MODE_LSB +: MODE_W]),
        .record_length (s_axis_tdata[RECLEN_LSB +: RECLEN_W]),
        .data_byte     (s_axis_tdata[BYTE_LSB +: BYTE_W]),
        .out_byte      (m_axis_tdata),
        .run_last      (m_axis_tuser),
        .record_end    (m_axis_tlast)
    );

endmodule

@@ rtl/core/drbs_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the descriptor record byte swapper, bound to the top level
// depends on drbs_pkg and descriptor_record_byte_swapper

module drbs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [drbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input logic [drbs_pkg::FUNC_W-1:0]         s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [drbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                m_axis_tuser,
    input logic                                m_axis_tlast
);
    import drbs_pkg::*;

    // the final byte of a record always closes its word's results
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("record end without run last");

    // no new word is taken while results are still waiting
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output pending");

    // a record start gives no result
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (func_t'(s_axis_tuser) == FUNC_START)
        |=> !m_axis_tvalid)
        else $error("output after record start");

    // after a descriptor write the input is ready again in the next cycle
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (func_t'(s_axis_tuser) == FUNC_WRITE)
        |=> s_axis_tready)
        else $error("descriptor write stalled input");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind descriptor_record_byte_swapper drbs_checker u_drbs_checker (.*);
